FILE: hw/rtl/ptrt_pkg.sv
// ptrt_pkg: shared types and constants for the periodic task release table.
// No dependencies.
package ptrt_pkg;
  localparam int MaxTasks = 16;
  localparam int IdxW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_ADD = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [2:0] ST_RELEASE = 3'd0;
  localparam logic [2:0] ST_ADDED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_ZERO = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic           latch;      // capture the request
    logic           tick_inc;   // advance tick count
    logic           rd;         // read entry at idx
    logic [IdxW-1:0] idx;
    logic           mod_start;  // start modulo of num by den
    logic           mod_tick;   // 1: (ticks - phase) mod period, 0: ticks mod new period
    logic           wr_add;     // append new entry
    logic           shift;      // copy entry idx+1 into idx
    logic           dec;        // count minus one
  } cmd_t;

  typedef struct packed {
    logic            mod_done;
    logic            mod_zero;
    logic            id_match;
    logic [CntW-1:0] count;
  } sts_t;
endpackage

FILE: hw/rtl/periodic_task_release_table.sv
// periodic_task_release_table: top level, controller plus datapath.
// Depends on ptrt_pkg, ptrt_ctrl, ptrt_datapath.
//
// One request at a time. A tick scans the table entry by entry; each entry
// is checked by the bit-serial 32-by-16 modulo unit (one quotient bit per
// cycle), and the scan waits while the receiver stalls. An add runs one
// modulo for the phase; a remove reads and compares entries until the id
// matches, then moves each later entry down one place. Releases of a tick
// come out in table order, the last one flagged. Adds to a full table and
// adds with zero period are refused. Func code 3 is dropped without effect
// or result.
module periodic_task_release_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  func,
  input  logic [7:0]  task_id,
  input  logic [31:0] context_req,
  input  logic [15:0] period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        released,
  output logic [7:0]  task_id_out,
  output logic [31:0] context_out,
  output logic [2:0]  status,
  output logic        last
);
  ptrt_pkg::cmd_t cmd;
  ptrt_pkg::sts_t sts;
  logic [7:0]  rd_id, req_id;
  logic [31:0] rd_ctx, req_ctx;

  ptrt_datapath u_dp (
    .clk, .rst, .cmd, .sts, .task_id, .context_req, .period,
    .rd_id, .rd_ctx, .req_id, .req_ctx
  );

  ptrt_ctrl u_ctrl (
    .clk, .rst, .valid, .ready, .func, .period, .cmd, .sts,
    .rd_id, .rd_ctx, .req_id, .req_ctx,
    .out_valid, .out_ready, .released, .task_id_out, .context_out, .status, .last
  );

  // entry count never exceeds the table size
  a_count: assert property (@(posedge clk) disable iff (rst)
    sts.count <= ptrt_pkg::CntW'(ptrt_pkg::MaxTasks)) else $error("count overflow");
  // no request is taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready) else $error("ready with pending result");
  // an append never happens on a full table
  a_add: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_add |-> sts.count < ptrt_pkg::CntW'(ptrt_pkg::MaxTasks)) else $error("add when full");
endmodule

FILE: hw/rtl/ptrt_datapath.sv
// ptrt_datapath: entry memories, tick count and a bit-serial 32-by-16 modulo unit.
// Depends on ptrt_pkg.
module ptrt_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ptrt_pkg::cmd_t        cmd,
  output ptrt_pkg::sts_t        sts,
  input  logic [7:0]            task_id,
  input  logic [31:0]           context_req,
  input  logic [15:0]           period,
  output logic [7:0]            rd_id,
  output logic [31:0]           rd_ctx,
  output logic [7:0]            req_id,
  output logic [31:0]           req_ctx
);
  logic [7:0]  ids [ptrt_pkg::MaxTasks];
  logic [31:0] ctxs [ptrt_pkg::MaxTasks];
  logic [15:0] pers [ptrt_pkg::MaxTasks];
  logic [15:0] phs [ptrt_pkg::MaxTasks];
  logic [ptrt_pkg::CntW-1:0] count;
  logic [31:0] ticks;
  logic [15:0] req_per, rd_per, rd_ph;
  // modulo unit
  logic [31:0] num;
  logic [16:0] rem;
  logic [15:0] den;
  logic [5:0]  bits;
  logic        busy, done;
  logic [16:0] rem_sh;
  logic [ptrt_pkg::IdxW-1:0] widx, sidx;

  assign rem_sh = {rem[15:0], num[31]};
  assign widx = count[ptrt_pkg::IdxW-1:0];
  assign sidx = cmd.idx + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_id <= task_id;
      req_ctx <= context_req;
      req_per <= period;
    end
    if (cmd.rd) begin
      rd_id <= ids[cmd.idx];
      rd_ctx <= ctxs[cmd.idx];
      rd_per <= pers[cmd.idx];
      rd_ph <= phs[cmd.idx];
    end
    if (cmd.wr_add) begin
      ids[widx] <= req_id;
      ctxs[widx] <= req_ctx;
      pers[widx] <= req_per;
      phs[widx] <= rem[15:0];
    end
    if (cmd.shift) begin
      ids[cmd.idx] <= ids[sidx];
      ctxs[cmd.idx] <= ctxs[sidx];
      pers[cmd.idx] <= pers[sidx];
      phs[cmd.idx] <= phs[sidx];
    end
    if (cmd.mod_start) begin
      num <= cmd.mod_tick ? ticks - {16'd0, rd_ph} : ticks;
      den <= cmd.mod_tick ? rd_per : req_per;
      rem <= '0;
      bits <= '0;
    end else if (busy) begin
      num <= {num[30:0], 1'b0};
      rem <= (rem_sh >= {1'b0, den}) ? rem_sh - {1'b0, den} : rem_sh;
      bits <= bits + 6'd1;
    end
  end

  // done stays high from the end of a modulo until the next one starts
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ticks <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cmd.tick_inc) ticks <= ticks + 32'd1;
      if (cmd.wr_add) count <= count + 1'b1;
      if (cmd.dec) count <= count - 1'b1;
      if (cmd.mod_start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && bits == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.mod_done = done;
    sts.mod_zero = (rem[15:0] == 16'd0);
    sts.id_match = (rd_id == req_id);
    sts.count = count;
  end
endmodule

FILE: hw/rtl/ptrt_ctrl.sv
// ptrt_ctrl: request sequencer and result register for the release table.
// Depends on ptrt_pkg.
module ptrt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid,
  output logic           ready,
  input  logic [1:0]     func,
  input  logic [15:0]    period,
  output ptrt_pkg::cmd_t cmd,
  input  ptrt_pkg::sts_t sts,
  input  logic [7:0]     rd_id,
  input  logic [31:0]    rd_ctx,
  input  logic [7:0]     req_id,
  input  logic [31:0]    req_ctx,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           released,
  output logic [7:0]     task_id_out,
  output logic [31:0]    context_out,
  output logic [2:0]     status,
  output logic           last
);
  typedef enum logic [3:0] {
    S_IDLE, S_ADD_MOD, S_ADD_WAIT, S_TRD, S_TCHK, S_TWAIT, S_RRD, S_RCHK, S_SHIFT,
    S_OUT
  } state_t;
  state_t state;
  logic [ptrt_pkg::IdxW-1:0] idx;
  logic [ptrt_pkg::CntW-1:0] pos;
  logic [1:0] func_r;
  logic       have;                 // tick release held in pend regs; for a remove, entry found
  logic [7:0]  pend_id;
  logic [31:0] pend_ctx;
  logic       full;
  logic [ptrt_pkg::CntW-1:0] nxt;
  logic       out_free;
  logic       emit;
  logic       addok;

  assign ready = (state == S_IDLE) && !out_valid;
  assign full = (sts.count == ptrt_pkg::CntW'(ptrt_pkg::MaxTasks));
  assign nxt = pos + 1'b1;
  assign out_free = !out_valid || out_ready;
  assign emit = out_free &&
                (((state == S_TWAIT) && sts.mod_done && sts.mod_zero && have) ||
                 ((state == S_OUT) && (func_r != ptrt_pkg::FUNC_TICK || have)));

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    cmd.latch = valid && ready;
    cmd.tick_inc = valid && ready && func == ptrt_pkg::FUNC_TICK;
    unique case (state)
      S_ADD_MOD: cmd.mod_start = 1'b1;
      S_ADD_WAIT: cmd.wr_add = sts.mod_done;
      S_TRD, S_RRD: cmd.rd = 1'b1;
      S_TCHK: begin
        cmd.mod_start = 1'b1;
        cmd.mod_tick = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift = (nxt < sts.count);
        cmd.dec = !(nxt < sts.count);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      have <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (valid && ready) begin
          func_r <= func;
          idx <= '0;
          pos <= '0;
          have <= 1'b0;
          unique case (func)
            ptrt_pkg::FUNC_TICK: state <= (sts.count == '0) ? S_IDLE : S_TRD;
            ptrt_pkg::FUNC_ADD: begin
              if (full || period == 16'd0) state <= S_OUT;
              else state <= S_ADD_MOD;
            end
            ptrt_pkg::FUNC_REMOVE: state <= (sts.count == '0) ? S_OUT : S_RRD;
            default: state <= S_IDLE;
          endcase
        end
        S_ADD_MOD: state <= S_ADD_WAIT;
        S_ADD_WAIT: if (sts.mod_done) state <= S_OUT;
        S_TRD: state <= S_TCHK;
        S_TCHK: state <= S_TWAIT;
        S_TWAIT: if (sts.mod_done && out_free) begin
          // hold a found release until it is known whether it is the last;
          // send the one held before it, which is not
          if (sts.mod_zero) begin
            if (have) begin
              released <= 1'b1;
              task_id_out <= pend_id;
              context_out <= pend_ctx;
              status <= ptrt_pkg::ST_RELEASE;
              last <= 1'b0;
            end
            pend_id <= rd_id;
            pend_ctx <= rd_ctx;
            have <= 1'b1;
          end
          if (nxt == sts.count) begin
            state <= S_OUT;
          end else begin
            pos <= nxt;
            idx <= nxt[ptrt_pkg::IdxW-1:0];
            state <= S_TRD;
          end
        end
        S_RRD: state <= S_RCHK;
        S_RCHK: if (sts.id_match) begin
          state <= S_SHIFT;
        end else if (nxt == sts.count) begin
          state <= S_OUT;
        end else begin
          pos <= nxt;
          idx <= nxt[ptrt_pkg::IdxW-1:0];
          state <= S_RRD;
        end
        S_SHIFT: if (nxt < sts.count) begin
          pos <= nxt;
          idx <= nxt[ptrt_pkg::IdxW-1:0];
        end else begin
          have <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_free) begin
          state <= S_IDLE;
          last <= 1'b1;
          if (func_r == ptrt_pkg::FUNC_TICK) begin
            released <= 1'b1;
            task_id_out <= pend_id;
            context_out <= pend_ctx;
            status <= ptrt_pkg::ST_RELEASE;
          end else if (func_r == ptrt_pkg::FUNC_REMOVE) begin
            released <= 1'b0;
            task_id_out <= req_id;
            context_out <= '0;
            status <= have ? ptrt_pkg::ST_REMOVED : ptrt_pkg::ST_NOTFOUND;
          end else if (addok) begin
            released <= 1'b1;
            task_id_out <= req_id;
            context_out <= req_ctx;
            status <= ptrt_pkg::ST_ADDED;
          end else begin
            released <= 1'b0;
            task_id_out <= req_id;
            context_out <= '0;
            status <= full ? ptrt_pkg::ST_FULL : ptrt_pkg::ST_ZERO;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // add succeeded: marked when the new entry was written
  always_ff @(posedge clk) begin
    if (rst) addok <= 1'b0;
    else if (valid && ready) addok <= 1'b0;
    else if (cmd.wr_add) addok <= 1'b1;
  end
endmodule
